@@ hw/rtl/pow2_class_block_allocator_unit_assert.svh @@
// Assertion macros for the allocator RTL; pcba_ctrl includes them.
`ifndef POW2_CLASS_BLOCK_ALLOCATOR_UNIT_ASSERT_SVH
`define POW2_CLASS_BLOCK_ALLOCATOR_UNIT_ASSERT_SVH

// Checked property, disabled while reset is asserted.
`define PCBA_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("pcba: assertion failed");

// Checked property that also holds during reset.
`define PCBA_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("pcba: assertion failed");

`endif

@@ hw/rtl/pcba_pkg.sv @@
// ----------------------------------------------------------------------------
// pcba_pkg
// Shared constants for the power-of-two class block allocator.
// ----------------------------------------------------------------------------
package pcba_pkg;

    // default geometry
    localparam int NUM_CLASSES_DEF   = 16;
    localparam int MIN_BLOCK_LOG_DEF = 5;
    localparam int ARENA_LOG_DEF     = 20;
    localparam int MAX_ARENAS_DEF    = 4;
    localparam int HEADER_BYTES_DEF  = 8;

    // fixed field widths
    localparam int REQ_W    = 24;
    localparam int ADDR_W   = 22;
    localparam int CLS_W    = 4;
    localparam int STAT_W   = 2;
    localparam int LIMIT_W  = 3;
    localparam int LIMIT_RST = 4;

    // command codes
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // status codes
    localparam logic [STAT_W-1:0] STAT_ALLOCATED = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FREED     = 2'd1;
    localparam logic [STAT_W-1:0] STAT_TOO_LARGE = 2'd2;
    localparam logic [STAT_W-1:0] STAT_NO_MEMORY = 2'd3;

endpackage

@@ hw/rtl/pcba_ram.sv @@
// ----------------------------------------------------------------------------
// pcba_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module pcba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ hw/rtl/pcba_ctrl.sv @@
// ----------------------------------------------------------------------------
// pcba_ctrl
// Sequencer for allocate and free: class heads, split cascade, memory
// read-modify-write and the result register.
// ----------------------------------------------------------------------------
`include "pow2_class_block_allocator_unit_assert.svh"

module pcba_ctrl #(
    parameter int NUM_CLASSES   = pcba_pkg::NUM_CLASSES_DEF,
    parameter int MIN_BLOCK_LOG = pcba_pkg::MIN_BLOCK_LOG_DEF,
    parameter int ARENA_LOG     = pcba_pkg::ARENA_LOG_DEF,
    parameter int MAX_ARENAS    = pcba_pkg::MAX_ARENAS_DEF,
    parameter int HEADER_BYTES  = pcba_pkg::HEADER_BYTES_DEF,
    localparam int GRANULES = MAX_ARENAS << (ARENA_LOG - MIN_BLOCK_LOG),
    localparam int GW  = $clog2(GRANULES),
    localparam int HW  = GW + 1,
    localparam int CW  = $clog2(NUM_CLASSES)
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [pcba_pkg::LIMIT_W-1:0]  arena_limit,
    // input item
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic                          s_cmd,
    input  logic [pcba_pkg::REQ_W-1:0]    s_req,
    input  logic [pcba_pkg::ADDR_W-1:0]   s_addr,
    // result item
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [pcba_pkg::ADDR_W-1:0]   m_addr,
    output logic [pcba_pkg::CLS_W-1:0]    m_cls,
    output logic [pcba_pkg::STAT_W-1:0]   m_stat,
    // link memory
    output logic                          lnk_we,
    output logic [GW-1:0]                 lnk_waddr,
    output logic [HW-1:0]                 lnk_wdata,
    output logic [GW-1:0]                 lnk_raddr,
    input  logic [HW-1:0]                 lnk_rdata,
    // class memory
    output logic                          cls_we,
    output logic [GW-1:0]                 cls_waddr,
    output logic [CW-1:0]                 cls_wdata,
    output logic [GW-1:0]                 cls_raddr,
    input  logic [CW-1:0]                 cls_rdata
);

    localparam int TOT_W  = 34;
    localparam int FG_W   = pcba_pkg::ADDR_W - MIN_BLOCK_LOG;
    localparam int AU_W   = $clog2(MAX_ARENAS + 1);
    localparam logic [CW-1:0] TOP = CW'(NUM_CLASSES - 1);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_CALC    = 4'd1;
    localparam logic [3:0] S_FREE_RD = 4'd2;
    localparam logic [3:0] S_FREE_WR = 4'd3;
    localparam logic [3:0] S_POP_RD  = 4'd4;
    localparam logic [3:0] S_POP_WR  = 4'd5;
    localparam logic [3:0] S_SPLIT   = 4'd6;
    localparam logic [3:0] S_FIN_RD  = 4'd7;
    localparam logic [3:0] S_FIN_WR  = 4'd8;
    localparam logic [3:0] S_DONE    = 4'd9;

    logic [3:0]                    state_reg, state_next;
    logic [HW-1:0]                 heads_reg [NUM_CLASSES];
    logic [HW-1:0]                 heads_next [NUM_CLASSES];
    logic [AU_W-1:0]               used_reg, used_next;
    logic                          cmd_reg, cmd_next;
    logic [pcba_pkg::REQ_W-1:0]    req_reg, req_next;
    logic [pcba_pkg::ADDR_W-1:0]   addr_reg, addr_next;
    logic [CW-1:0]                 k_reg, k_next;
    logic [CW-1:0]                 lvl_reg, lvl_next;
    logic [GW-1:0]                 blk_reg, blk_next;
    logic [pcba_pkg::ADDR_W-1:0]   res_addr_reg, res_addr_next;
    logic [CW-1:0]                 res_cls_reg, res_cls_next;
    logic [pcba_pkg::STAT_W-1:0]   res_stat_reg, res_stat_next;
    logic                          mv_reg, mv_next;
    logic [pcba_pkg::ADDR_W-1:0]   ma_reg, ma_next;
    logic [CW-1:0]                 mc_reg, mc_next;
    logic [pcba_pkg::STAT_W-1:0]   ms_reg, ms_next;

    logic [CW-1:0]                 hd_addr;
    logic [HW-1:0]                 hd_rd;
    logic [NUM_CLASSES-1:0]        hd_valid;
    logic [TOT_W-1:0]              total;
    logic                          too_large;
    logic [CW-1:0]                 k_calc;
    logic [CW-1:0]                 j_calc;
    logic                          j_found;
    logic [AU_W-1:0]               limit;
    logic [FG_W-1:0]               free_gran;
    logic                          free_oob;
    logic [GW-1:0]                 arena_gran;
    logic [GW-1:0]                 half_gran;
    logic [CW-1:0]                 free_cls;
    logic                          out_free;

    // head read port and valid bits
    assign hd_rd = heads_reg[hd_addr];
    always_comb begin
        for (int c = 0; c < NUM_CLASSES; c++) begin
            hd_valid[c] = heads_reg[c][HW-1];
        end
    end

    // request sizing
    assign total = TOT_W'(req_reg) + TOT_W'(HEADER_BYTES);
    assign too_large = total > (TOT_W'(1) << (NUM_CLASSES - 1 + MIN_BLOCK_LOG));
    always_comb begin
        k_calc = '0;
        for (int c = 0; c < NUM_CLASSES - 1; c++) begin
            if ((TOT_W'(1) << (c + MIN_BLOCK_LOG)) < total) begin
                k_calc = CW'(c + 1);
            end
        end
    end

    // nearest non-empty class at or above the request
    always_comb begin
        j_calc  = TOP;
        j_found = 1'b0;
        for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
            if (CW'(c) >= k_calc && hd_valid[c]) begin
                j_calc  = CW'(c);
                j_found = 1'b1;
            end
        end
    end

    assign limit = (32'(arena_limit) < 32'(MAX_ARENAS)) ? AU_W'(arena_limit)
                                                      : AU_W'(MAX_ARENAS);
    assign free_gran  = addr_reg[pcba_pkg::ADDR_W-1:MIN_BLOCK_LOG];
    assign free_oob   = 32'(free_gran) >= 32'(GRANULES);
    assign arena_gran = GW'(used_reg) << (ARENA_LOG - MIN_BLOCK_LOG);
    assign half_gran  = GW'(1) << (lvl_reg - CW'(1));
    assign free_cls   = (cls_rdata > TOP) ? TOP : cls_rdata;
    assign out_free   = !mv_reg || m_tready;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = mv_reg;
    assign m_addr   = ma_reg;
    assign m_cls    = pcba_pkg::CLS_W'(mc_reg);
    assign m_stat   = ms_reg;

    // sequencer
    always_comb begin
        state_next    = state_reg;
        heads_next    = heads_reg;
        used_next     = used_reg;
        cmd_next      = cmd_reg;
        req_next      = req_reg;
        addr_next     = addr_reg;
        k_next        = k_reg;
        lvl_next      = lvl_reg;
        blk_next      = blk_reg;
        res_addr_next = res_addr_reg;
        res_cls_next  = res_cls_reg;
        res_stat_next = res_stat_reg;
        hd_addr       = lvl_reg;
        lnk_we        = 1'b0;
        lnk_waddr     = blk_reg;
        lnk_wdata     = hd_rd;
        lnk_raddr     = hd_rd[GW-1:0];
        cls_we        = 1'b0;
        cls_waddr     = blk_reg;
        cls_wdata     = k_reg;
        cls_raddr     = GW'(free_gran);
        mv_next       = mv_reg && !m_tready;
        ma_next       = ma_reg;
        mc_next       = mc_reg;
        ms_next       = ms_reg;

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd_next   = s_cmd;
                    req_next   = s_req;
                    addr_next  = s_addr;
                    state_next = (s_cmd == pcba_pkg::CMD_FREE) ? S_FREE_RD : S_CALC;
                end
            end
            S_CALC: begin
                k_next  = k_calc;
                hd_addr = TOP;
                if (too_large) begin
                    res_addr_next = '0;
                    res_cls_next  = '0;
                    res_stat_next = pcba_pkg::STAT_TOO_LARGE;
                    state_next    = S_DONE;
                end else if (j_found) begin
                    lvl_next   = j_calc;
                    state_next = (j_calc == k_calc) ? S_FIN_RD : S_POP_RD;
                end else if (used_reg >= limit) begin
                    res_addr_next = '0;
                    res_cls_next  = k_calc;
                    res_stat_next = pcba_pkg::STAT_NO_MEMORY;
                    state_next    = S_DONE;
                end else begin
                    // claim a fresh arena onto the top class
                    lnk_we          = 1'b1;
                    lnk_waddr       = arena_gran;
                    lnk_wdata       = hd_rd;
                    heads_next[TOP] = {1'b1, arena_gran};
                    used_next       = used_reg + AU_W'(1);
                    lvl_next        = TOP;
                    state_next      = (TOP == k_calc) ? S_FIN_RD : S_POP_RD;
                end
            end
            S_FREE_RD: begin
                res_addr_next = pcba_pkg::ADDR_W'({free_gran, {MIN_BLOCK_LOG{1'b0}}});
                res_cls_next  = '0;
                res_stat_next = pcba_pkg::STAT_FREED;
                state_next    = free_oob ? S_DONE : S_FREE_WR;
            end
            S_FREE_WR: begin
                // push the freed block onto its recorded class
                hd_addr              = free_cls;
                lnk_we               = 1'b1;
                lnk_waddr            = GW'(free_gran);
                lnk_wdata            = hd_rd;
                heads_next[free_cls] = {1'b1, GW'(free_gran)};
                res_cls_next         = free_cls;
                state_next           = S_DONE;
            end
            S_POP_RD: begin
                hd_addr    = lvl_reg;
                lnk_raddr  = hd_rd[GW-1:0];
                blk_next   = hd_rd[GW-1:0];
                state_next = S_POP_WR;
            end
            S_POP_WR: begin
                // pop, then push the upper half one class down
                heads_next[lvl_reg]          = lnk_rdata;
                lnk_we                       = 1'b1;
                lnk_waddr                    = blk_reg + half_gran;
                lnk_wdata                    = '0;
                heads_next[lvl_reg - CW'(1)] = {1'b1, blk_reg + half_gran};
                state_next                   = S_SPLIT;
            end
            S_SPLIT: begin
                // lower half goes on top
                lnk_we                       = 1'b1;
                lnk_waddr                    = blk_reg;
                lnk_wdata                    = {1'b1, blk_reg + half_gran};
                heads_next[lvl_reg - CW'(1)] = {1'b1, blk_reg};
                lvl_next                     = lvl_reg - CW'(1);
                state_next = ((lvl_reg - CW'(1)) == k_reg) ? S_FIN_RD : S_POP_RD;
            end
            S_FIN_RD: begin
                hd_addr    = k_reg;
                lnk_raddr  = hd_rd[GW-1:0];
                blk_next   = hd_rd[GW-1:0];
                state_next = S_FIN_WR;
            end
            S_FIN_WR: begin
                heads_next[k_reg] = lnk_rdata;
                cls_we            = 1'b1;
                cls_waddr         = blk_reg;
                cls_wdata         = k_reg;
                res_addr_next     = pcba_pkg::ADDR_W'({blk_reg, {MIN_BLOCK_LOG{1'b0}}});
                res_cls_next      = k_reg;
                res_stat_next     = pcba_pkg::STAT_ALLOCATED;
                state_next        = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    mv_next    = 1'b1;
                    ma_next    = res_addr_reg;
                    mc_next    = res_cls_reg;
                    ms_next    = res_stat_reg;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            used_reg  <= '0;
            mv_reg    <= 1'b0;
            for (int c = 0; c < NUM_CLASSES; c++) begin
                heads_reg[c] <= '0;
            end
        end else begin
            state_reg <= state_next;
            used_reg  <= used_next;
            mv_reg    <= mv_next;
            heads_reg <= heads_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        cmd_reg      <= cmd_next;
        req_reg      <= req_next;
        addr_reg     <= addr_next;
        k_reg        <= k_next;
        lvl_reg      <= lvl_next;
        blk_reg      <= blk_next;
        res_addr_reg <= res_addr_next;
        res_cls_reg  <= res_cls_next;
        res_stat_reg <= res_stat_next;
        ma_reg       <= ma_next;
        mc_reg       <= mc_next;
        ms_reg       <= ms_next;
    end

    // checks
    `PCBA_ASSERT(a_used_bound, aclk, aresetn, used_reg <= AU_W'(MAX_ARENAS))
    `PCBA_ASSERT(a_pop_nonempty, aclk, aresetn, (state_reg == S_POP_RD) |-> hd_valid[lvl_reg])
    `PCBA_ASSERT(a_fin_nonempty, aclk, aresetn, (state_reg == S_FIN_RD) |-> hd_valid[k_reg])
    `PCBA_ASSERT(a_done_emits, aclk, aresetn, (state_reg == S_DONE && out_free) |=> m_tvalid)
    `PCBA_ASSERT(a_free_cmd, aclk, aresetn, (state_reg == S_FREE_WR) |-> (cmd_reg == pcba_pkg::CMD_FREE))

endmodule

@@ hw/rtl/pow2_class_block_allocator_unit.sv @@
// ----------------------------------------------------------------------------
// pow2_class_block_allocator_unit
// Power-of-two segregated free-list block allocator with LIFO class lists.
// ----------------------------------------------------------------------------
// channel | dir | handshake          | payload
// s_      | in  | s_tvalid/s_tready  | tdata: request_bytes, block_address; tuser: command
// m_      | out | m_tvalid/m_tready  | tdata: granted_address, granted_class; tuser: status
// cfg_    | in  | cfg_valid/cfg_ready| cfg_data: arena_limit
//
// One item at a time. A free reads the block's class, then pushes it onto that class;
// an allocate sizes the request, splits one class per level through the link memory
// and then pops its own class. Too-large and out-of-memory allocates skip the lists.
// No clearing pass after reset; class heads and arena count clear at once.
// A result waits in the output register while the next item is accepted.
// ----------------------------------------------------------------------------
module pow2_class_block_allocator_unit #(
    parameter int NUM_CLASSES   = pcba_pkg::NUM_CLASSES_DEF,
    parameter int MIN_BLOCK_LOG = pcba_pkg::MIN_BLOCK_LOG_DEF,
    parameter int ARENA_LOG     = pcba_pkg::ARENA_LOG_DEF,
    parameter int MAX_ARENAS    = pcba_pkg::MAX_ARENAS_DEF,
    parameter int HEADER_BYTES  = pcba_pkg::HEADER_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // [23:0] request_bytes, [45:24] block_address
    input  logic        s_tuser,   // [0] command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [21:0] granted_address, [25:22] granted_class
    output logic [1:0]  m_tuser,   // [1:0] status
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_data   // arena_limit
);

    localparam int GRANULES = MAX_ARENAS << (ARENA_LOG - MIN_BLOCK_LOG);
    localparam int GW = $clog2(GRANULES);
    localparam int HW = GW + 1;
    localparam int CW = $clog2(NUM_CLASSES);

    logic [pcba_pkg::LIMIT_W-1:0] limit_reg;
    logic                        lnk_we, cls_we;
    logic [GW-1:0]               lnk_waddr, lnk_raddr, cls_waddr, cls_raddr;
    logic [HW-1:0]               lnk_wdata, lnk_rdata;
    logic [CW-1:0]               cls_wdata, cls_rdata;
    logic [pcba_pkg::ADDR_W-1:0] m_addr;
    logic [pcba_pkg::CLS_W-1:0]  m_cls;

    // configuration register
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= pcba_pkg::LIMIT_W'(pcba_pkg::LIMIT_RST);
        end else if (cfg_valid) begin
            limit_reg <= cfg_data;
        end
    end

    assign m_tdata = {6'd0, m_cls, m_addr};

    pcba_ctrl #(
        .NUM_CLASSES  (NUM_CLASSES),
        .MIN_BLOCK_LOG(MIN_BLOCK_LOG),
        .ARENA_LOG    (ARENA_LOG),
        .MAX_ARENAS   (MAX_ARENAS),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .arena_limit(limit_reg),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_cmd      (s_tuser),
        .s_req      (s_tdata[23:0]),
        .s_addr     (s_tdata[45:24]),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_addr     (m_addr),
        .m_cls      (m_cls),
        .m_stat     (m_tuser),
        .lnk_we     (lnk_we),
        .lnk_waddr  (lnk_waddr),
        .lnk_wdata  (lnk_wdata),
        .lnk_raddr  (lnk_raddr),
        .lnk_rdata  (lnk_rdata),
        .cls_we     (cls_we),
        .cls_waddr  (cls_waddr),
        .cls_wdata  (cls_wdata),
        .cls_raddr  (cls_raddr),
        .cls_rdata  (cls_rdata)
    );

    // next-link store, one entry per granule
    pcba_ram #(.WIDTH(HW), .DEPTH(GRANULES)) u_link_ram (
        .aclk (aclk),
        .we   (lnk_we),
        .waddr(lnk_waddr),
        .wdata(lnk_wdata),
        .raddr(lnk_raddr),
        .rdata(lnk_rdata)
    );

    // block class store, one entry per granule
    pcba_ram #(.WIDTH(CW), .DEPTH(GRANULES)) u_class_ram (
        .aclk (aclk),
        .we   (cls_we),
        .waddr(cls_waddr),
        .wdata(cls_wdata),
        .raddr(cls_raddr),
        .rdata(cls_rdata)
    );

endmodule
